[sv/min_sliding_window_sum_assert.svh]
// Assertion macros for the minimum sliding window sum block.
// Included by the checker module; needs no other file.
`ifndef MIN_SLIDING_WINDOW_SUM_ASSERT_SVH
`define MIN_SLIDING_WINDOW_SUM_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define MSWS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("min_sliding_window_sum: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define MSWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("min_sliding_window_sum: next-cycle check failed");

`endif

[sv/msws_pkg.sv]
// Shared types and constants for the minimum sliding window sum block.
// No dependencies; imported by every file of the block but msws_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package msws_pkg;

   localparam int COUNT_W    = 16;
   localparam int RIVER_W    = 17;
   localparam int STEP_W     = 11;
   localparam int POS_W      = 16;
   localparam int SUM_W      = 27;
   localparam int OUT_W      = 27;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [RIVER_W-1:0] RIVER_CAP = 17'd65536;
   localparam logic signed [OUT_W-1:0] OUT_INVALID = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RIVER_WIDTH = 1'b0,
      CSR_STEP_LENGTH = 1'b1
   } csr_index_type;

   // One count on its way from the accept stage to the accumulate stage
   typedef struct packed {
      logic               valid;
      logic               invalid;
      logic               in_fill;
      logic               set_least;
      logic               do_cmp;
      logic               last;
      logic               fwd;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] fwd_data;
   } msws_stage_type;

endpackage

`default_nettype wire

[sv/msws_if.sv]
// Valid/ready channel interfaces for the count stream and the result stream.
// Depends on msws_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msws_req_if;
   import msws_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] stone_count;
   modport source (output valid, output stone_count, input ready);
   modport sink (input valid, input stone_count, output ready);
endinterface

interface msws_rsp_if;
   import msws_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] least_window_sum;
   modport source (output valid, output least_window_sum, input ready);
   modport sink (input valid, input least_window_sum, output ready);
endinterface

`default_nettype wire

[sv/msws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module msws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/msws_ctrl.sv]
// Accept stage: tracks the set position and delay-line pointer, issues the
// delay-line read and forwards a same-address write. Depends on msws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msws_ctrl #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                restart,
   input  logic [msws_pkg::RIVER_W-1:0]        river_width,
   input  logic [msws_pkg::STEP_W-1:0]         step_length,
   input  logic                                req_valid,
   input  logic [msws_pkg::COUNT_W-1:0]        req_count,
   input  logic                                advance,
   output logic                                req_ready,
   output logic                                rd_en,
   output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_addr,
   output logic                                wr_en,
   output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] wr_addr,
   output logic [msws_pkg::COUNT_W-1:0]        wr_data,
   output msws_pkg::msws_stage_type            stage
);
   import msws_pkg::*;

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [PTR_W-1:0]   stage_addr_ff, stage_addr_in;
   msws_stage_type     stage_ff, stage_in;
   logic [RIVER_W-1:0] river_cap;
   logic [RIVER_W-1:0] set_len;
   logic [RIVER_W-1:0] pos_next;
   logic               settings_ok;
   logic               accept;
   logic               ptr_wrap;
   logic               last;

   // Decode the settings
   assign river_cap   = (river_width > RIVER_CAP) ? RIVER_CAP : river_width;
   assign set_len     = river_cap - RIVER_W'(1);
   assign settings_ok = (step_length != '0) && (river_width != '0)
                        && (river_cap > RIVER_W'(step_length))
                        && (32'(step_length) <= 32'(MAX_WINDOW));

   assign accept    = req_valid && advance;
   assign req_ready = advance;
   assign pos_next  = RIVER_W'(pos_ff) + RIVER_W'(1);
   assign last      = pos_next >= set_len;
   assign ptr_wrap  = (32'(ptr_ff) + 32'd1) >= 32'(step_length);

   // Read the entry that this count displaces
   assign rd_en   = accept;
   assign rd_addr = ptr_ff;

   // Write the count of the item leaving the accumulate stage
   assign wr_en   = stage_ff.valid && !stage_ff.invalid && advance;
   assign wr_addr = stage_addr_ff;
   assign wr_data = stage_ff.count;
   assign stage   = stage_ff;

   // Advance position and pointer, build the stage transaction
   always_comb begin
      pos_in        = pos_ff;
      ptr_in        = ptr_ff;
      stage_in      = stage_ff;
      stage_addr_in = stage_addr_ff;
      if (advance) begin
         stage_in.valid = 1'b0;
      end
      if (restart) begin
         pos_in = '0;
         ptr_in = '0;
      end else if (accept) begin
         stage_in.valid     = 1'b1;
         stage_in.invalid   = !settings_ok;
         stage_in.in_fill   = RIVER_W'(pos_ff) < RIVER_W'(step_length);
         stage_in.set_least = pos_next == RIVER_W'(step_length);
         stage_in.do_cmp    = RIVER_W'(pos_ff) >= RIVER_W'(step_length);
         stage_in.last      = last;
         stage_in.count     = req_count;
         stage_in.fwd       = wr_en && (stage_addr_ff == ptr_ff);
         stage_in.fwd_data  = stage_ff.count;
         stage_addr_in      = ptr_ff;
         if (!settings_ok || last) begin
            pos_in = '0;
            ptr_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            ptr_in = ptr_wrap ? '0 : ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         ptr_ff        <= '0;
         stage_ff      <= '0;
         stage_addr_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         ptr_ff        <= ptr_in;
         stage_ff      <= stage_in;
         stage_addr_ff <= stage_addr_in;
      end
   end

endmodule

`default_nettype wire

[sv/msws_accum.sv]
// Accumulate stage: running window sum, least sum and the result register.
// Depends on msws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msws_accum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  msws_pkg::msws_stage_type          stage,
   input  logic [msws_pkg::COUNT_W-1:0]      rd_data,
   input  logic                              rsp_ready,
   output logic                              advance,
   output logic                              rsp_valid,
   output logic signed [msws_pkg::OUT_W-1:0] rsp_data
);
   import msws_pkg::*;

   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SUM_W-1:0]        least_ff, least_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]      old_count;
   logic [SUM_W-1:0]        sum_calc;
   logic [SUM_W-1:0]        least_calc;
   logic                    proc;

   // Hold the whole pipe while a result waits untaken
   assign advance = !rsp_valid_ff || rsp_ready;
   assign proc    = stage.valid && advance;

   // Drop the count leaving the window, add the new one
   assign old_count  = stage.fwd ? stage.fwd_data : rd_data;
   assign sum_calc   = (stage.in_fill ? sum_ff : sum_ff - SUM_W'(old_count))
                       + SUM_W'(stage.count);
   assign least_calc = stage.set_least ? sum_calc :
                       (stage.do_cmp && (sum_calc < least_ff)) ? sum_calc : least_ff;

   always_comb begin
      sum_in       = sum_ff;
      least_in     = least_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (restart) begin
         sum_in   = '0;
         least_in = '0;
      end else if (proc) begin
         if (stage.invalid) begin
            sum_in       = '0;
            least_in     = '0;
            rsp_data_in  = OUT_INVALID;
            rsp_valid_in = 1'b1;
         end else if (stage.last) begin
            sum_in       = '0;
            least_in     = '0;
            rsp_data_in  = OUT_W'(least_calc);
            rsp_valid_in = 1'b1;
         end else begin
            sum_in   = sum_calc;
            least_in = least_calc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         least_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         least_ff     <= least_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[sv/min_sliding_window_sum.sv]
// Minimum sliding window sum: top level with settings registers.
// Depends on msws_pkg, msws_if, msws_ram, msws_ctrl and msws_accum.
//
// Usage:
//   req_port carries one stone_count per transaction (valid/ready). A set is
//   river_width - 1 counts, with river_width capped at 65536; step_length is
//   the window length. On the last count of a set, rsp_port delivers one
//   transaction with the least sum over all full windows, then a new set
//   starts. With invalid settings every count gets a result of -1.
//   csr_we/csr_index/csr_wdata write river_width (0) or step_length (1);
//   any write restarts the set. Write only while the block is idle.
// Timing:
//   One count per cycle while no result is held unaccepted. On acceptance
//   of the last count, the delay-line read and the stage register load; the
//   accumulate stage then registers the result. The delay line sits in one
//   RAM with a registered read; a write to the entry being read in the same
//   cycle is forwarded.
// Reset: synchronous; clears settings, position, pointer, stage register,
//   sums and the result valid. The delay-line RAM needs no clearing:
//   entries are read only after they were written in the same set.
// Stall: while a result is held unaccepted, req_port.ready is low and the
//   pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

module min_sliding_window_sum #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   msws_req_if.sink                             req_port,
   msws_rsp_if.source                           rsp_port,
   input  logic                                 csr_we,
   input  logic [msws_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msws_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import msws_pkg::*;

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [RIVER_W-1:0] river_width_ff, river_width_in;
   logic [STEP_W-1:0]  step_length_ff, step_length_in;
   msws_stage_type     stage;
   logic               advance;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic [COUNT_W-1:0] rd_data;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [COUNT_W-1:0] wr_data;

   // Settings registers
   always_comb begin
      river_width_in = river_width_ff;
      step_length_in = step_length_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RIVER_WIDTH: begin
               river_width_in = csr_wdata[RIVER_W-1:0];
            end
            CSR_STEP_LENGTH: begin
               step_length_in = csr_wdata[STEP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         river_width_ff <= '0;
         step_length_ff <= STEP_W'(1);
      end else begin
         river_width_ff <= river_width_in;
         step_length_ff <= step_length_in;
      end
   end

   msws_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_we),
      .river_width (river_width_ff),
      .step_length (step_length_ff),
      .req_valid   (req_port.valid),
      .req_count   (req_port.stone_count),
      .advance     (advance),
      .req_ready   (req_port.ready),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .stage       (stage)
   );

   msws_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   msws_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_we),
      .stage     (stage),
      .rd_data   (rd_data),
      .rsp_ready (rsp_port.ready),
      .advance   (advance),
      .rsp_valid (rsp_port.valid),
      .rsp_data  (rsp_port.least_window_sum)
   );

endmodule

`default_nettype wire

[sv/msws_checker.sv]
// Port-level checker for the minimum sliding window sum block, bound to the
// top level. Depends on msws_pkg and min_sliding_window_sum_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "min_sliding_window_sum_assert.svh"

module msws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [msws_pkg::OUT_W-1:0] least_window_sum
);
   import msws_pkg::*;

   // No result right after reset
   `MSWS_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   // A held result keeps its value
   `MSWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(least_window_sum))
   // Input back-pressure comes only from a result waiting at the output
   `MSWS_ASSERT_HOLDS(a_ready_tracks_output, clock, reset, req_valid || !req_valid, req_ready == !(rsp_valid && !rsp_ready))
   // A result is either the invalid marker or a non-negative sum
   `MSWS_ASSERT_HOLDS(a_result_range, clock, reset, rsp_valid, least_window_sum == OUT_INVALID || !least_window_sum[OUT_W-1])

endmodule

bind min_sliding_window_sum msws_checker u_msws_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .least_window_sum (rsp_port.least_window_sum)
);

`default_nettype wire
